>>> rtl/cartridge_bank_and_cycle_irq_mapper_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cartridge bank and cycle IRQ mapper
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_AND_CYCLE_IRQ_MAPPER_TOP_ASSERT_SVH
`define CARTRIDGE_BANK_AND_CYCLE_IRQ_MAPPER_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define CBIM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define CBIM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, checked during reset too
`define CBIM_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/cbim_pkg.sv
// ----------------------------------------------------------------------------
// Cartridge bank and cycle IRQ mapper package
// Transaction types, address decode codes and counter constants.
// ----------------------------------------------------------------------------
package cbim_pkg;

  localparam int CHR_SLOTS  = 8;
  localparam int CHR_SLOT_W = $clog2(CHR_SLOTS);

  typedef struct packed {
    logic        mode;
    logic [15:0] address;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic                  irq_line;
    logic [4:0]            prg_bank_a;
    logic [4:0]            prg_bank_b;
    logic [4:0]            prg_bank_c;
    logic [7:0]            wram_bank;
    logic                  mirror_vertical;
    logic                  chr_update;
    logic [CHR_SLOT_W-1:0] chr_slot;
    logic [7:0]            chr_bank;
  } result_t;

  // address bits 15..12
  localparam logic [3:0] RGN_LATCH0    = 4'h8;
  localparam logic [3:0] RGN_LATCH1    = 4'h9;
  localparam logic [3:0] RGN_LATCH2    = 4'hA;
  localparam logic [3:0] RGN_LATCH3    = 4'hB;
  localparam logic [3:0] RGN_IRQ_CTRL  = 4'hC;
  localparam logic [3:0] RGN_IRQ_ACK   = 4'hD;
  localparam logic [3:0] RGN_BANK_SEL  = 4'hE;
  localparam logic [3:0] RGN_BANK_DATA = 4'hF;

  // address bits 11..10 within the bank data region
  localparam logic [1:0] SUB_PRG_HI = 2'b00;
  localparam logic [1:0] SUB_NONE   = 2'b01;
  localparam logic [1:0] SUB_MIRROR = 2'b10;
  localparam logic [1:0] SUB_CHR    = 2'b11;

  // bank-control targets
  localparam logic [3:0] SEL_PRG_A = 4'd1;
  localparam logic [3:0] SEL_PRG_B = 4'd2;
  localparam logic [3:0] SEL_PRG_C = 4'd3;
  localparam logic [3:0] SEL_WRAM  = 4'd4;

  // program bank index from address bits 1..0
  localparam logic [1:0] PRG_IDX_A = 2'd0;
  localparam logic [1:0] PRG_IDX_B = 2'd1;
  localparam logic [1:0] PRG_IDX_C = 2'd2;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

endpackage

>>> rtl/cbim_in_stage.sv
// ----------------------------------------------------------------------------
// Input register stage
// Captures one transaction and holds it until the core takes it.
// ----------------------------------------------------------------------------
module cbim_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cbim_pkg::item_t in_item,
  output logic           s_valid,
  output cbim_pkg::item_t s_item,
  input  logic           s_take
);

  logic            vld_r;
  logic            vld_nxt;
  cbim_pkg::item_t item_r;

  assign in_ready = !vld_r || s_take;
  assign vld_nxt  = in_ready ? in_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign s_valid = vld_r;
  assign s_item  = item_r;

endmodule

>>> rtl/cbim_core.sv
// ----------------------------------------------------------------------------
// Mapper core
// Decodes one transaction against the mapper state, updates the state and
// registers the result.
// ----------------------------------------------------------------------------
module cbim_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s_valid,
  input  cbim_pkg::item_t   s_item,
  output logic              s_take,
  output logic              out_valid,
  input  logic              out_ready,
  output cbim_pkg::result_t out_res
);

  logic [15:0] latch_r, latch_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        irq_en_r, irq_en_nxt;
  logic        irq_pend_r, irq_pend_nxt;
  logic [3:0]  bank_sel_r, bank_sel_nxt;
  logic [4:0]  prg_a_r, prg_a_nxt;
  logic [4:0]  prg_b_r, prg_b_nxt;
  logic [4:0]  prg_c_r, prg_c_nxt;
  logic [7:0]  wram_r, wram_nxt;
  logic        mirror_r, mirror_nxt;
  logic        chr_upd;
  logic [cbim_pkg::CHR_SLOT_W-1:0] chr_slot;
  logic [7:0]  chr_bank;
  logic        out_valid_r;
  cbim_pkg::result_t res_r;

  assign s_take = s_valid && (!out_valid_r || out_ready);

  always_comb begin
    latch_nxt    = latch_r;
    cnt_nxt      = cnt_r;
    irq_en_nxt   = irq_en_r;
    irq_pend_nxt = irq_pend_r;
    bank_sel_nxt = bank_sel_r;
    prg_a_nxt    = prg_a_r;
    prg_b_nxt    = prg_b_r;
    prg_c_nxt    = prg_c_r;
    wram_nxt     = wram_r;
    mirror_nxt   = mirror_r;
    chr_upd      = 1'b0;
    chr_slot     = '0;
    chr_bank     = '0;
    if (s_take) begin
      if (s_item.mode) begin
        if (irq_en_r) begin
          if (cnt_r == cbim_pkg::CNT_MAX) begin
            cnt_nxt      = latch_r;
            irq_pend_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 16'd1;
          end
        end
      end else begin
        unique case (s_item.address[15:12])
          cbim_pkg::RGN_LATCH0: latch_nxt[3:0]   = s_item.data[3:0];
          cbim_pkg::RGN_LATCH1: latch_nxt[7:4]   = s_item.data[3:0];
          cbim_pkg::RGN_LATCH2: latch_nxt[11:8]  = s_item.data[3:0];
          cbim_pkg::RGN_LATCH3: latch_nxt[15:12] = s_item.data[3:0];
          cbim_pkg::RGN_IRQ_CTRL: begin
            irq_en_nxt   = |s_item.data[3:0];
            irq_pend_nxt = 1'b0;
            if (|s_item.data[3:0]) begin
              cnt_nxt = latch_r;
            end
          end
          cbim_pkg::RGN_IRQ_ACK: irq_pend_nxt = 1'b0;
          cbim_pkg::RGN_BANK_SEL: bank_sel_nxt = s_item.data[3:0];
          cbim_pkg::RGN_BANK_DATA: begin
            unique case (bank_sel_r)
              cbim_pkg::SEL_PRG_A: prg_a_nxt[3:0] = s_item.data[3:0];
              cbim_pkg::SEL_PRG_B: prg_b_nxt[3:0] = s_item.data[3:0];
              cbim_pkg::SEL_PRG_C: prg_c_nxt[3:0] = s_item.data[3:0];
              cbim_pkg::SEL_WRAM:  wram_nxt       = s_item.data;
              default: ;
            endcase
            unique case (s_item.address[11:10])
              cbim_pkg::SUB_PRG_HI: begin
                unique case (s_item.address[1:0])
                  cbim_pkg::PRG_IDX_A: prg_a_nxt[4] = s_item.data[4];
                  cbim_pkg::PRG_IDX_B: prg_b_nxt[4] = s_item.data[4];
                  cbim_pkg::PRG_IDX_C: prg_c_nxt[4] = s_item.data[4];
                  default: ;
                endcase
              end
              cbim_pkg::SUB_NONE: ;
              cbim_pkg::SUB_MIRROR: mirror_nxt = s_item.data[0];
              cbim_pkg::SUB_CHR: begin
                chr_upd  = 1'b1;
                chr_slot = s_item.address[cbim_pkg::CHR_SLOT_W-1:0];
                chr_bank = s_item.data;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r     <= '0;
      cnt_r       <= '0;
      irq_en_r    <= 1'b0;
      irq_pend_r  <= 1'b0;
      bank_sel_r  <= '0;
      prg_a_r     <= '0;
      prg_b_r     <= '0;
      prg_c_r     <= '0;
      wram_r      <= '0;
      mirror_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      latch_r    <= latch_nxt;
      cnt_r      <= cnt_nxt;
      irq_en_r   <= irq_en_nxt;
      irq_pend_r <= irq_pend_nxt;
      bank_sel_r <= bank_sel_nxt;
      prg_a_r    <= prg_a_nxt;
      prg_b_r    <= prg_b_nxt;
      prg_c_r    <= prg_c_nxt;
      wram_r     <= wram_nxt;
      mirror_r   <= mirror_nxt;
      if (s_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_take) begin
      res_r.irq_line        <= irq_pend_nxt;
      res_r.prg_bank_a      <= prg_a_nxt;
      res_r.prg_bank_b      <= prg_b_nxt;
      res_r.prg_bank_c      <= prg_c_nxt;
      res_r.wram_bank       <= wram_nxt;
      res_r.mirror_vertical <= mirror_nxt;
      res_r.chr_update      <= chr_upd;
      res_r.chr_slot        <= chr_slot;
      res_r.chr_bank        <= chr_bank;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

>>> rtl/cartridge_bank_and_cycle_irq_mapper_top.sv
// ----------------------------------------------------------------------------
// Cartridge bank and cycle IRQ mapper
// Each transaction passes the input register, then the result register.
// Throughput: one transaction per cycle while out_ready stays high; a held
// result stalls the input once the input register is also full.
// The rate is set by the input register feeding the combinational decode and
// state update, which loads the result register.
// Reset: synchronous rst_n clears all mapper state and empties both stages.
// ----------------------------------------------------------------------------
module cartridge_bank_and_cycle_irq_mapper_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_irq_line,
  output logic [4:0]  out_prg_bank_a,
  output logic [4:0]  out_prg_bank_b,
  output logic [4:0]  out_prg_bank_c,
  output logic [7:0]  out_wram_bank,
  output logic        out_mirror_vertical,
  output logic        out_chr_update,
  output logic [2:0]  out_chr_slot,
  output logic [7:0]  out_chr_bank
);

  cbim_pkg::item_t   in_item;
  cbim_pkg::item_t   s_item;
  cbim_pkg::result_t res;
  logic              s_valid;
  logic              s_take;

  assign in_item.mode    = in_mode;
  assign in_item.address = in_address;
  assign in_item.data    = in_data;

  cbim_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .s_valid  (s_valid),
    .s_item   (s_item),
    .s_take   (s_take)
  );

  cbim_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_valid   (s_valid),
    .s_item    (s_item),
    .s_take    (s_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_irq_line        = res.irq_line;
  assign out_prg_bank_a      = res.prg_bank_a;
  assign out_prg_bank_b      = res.prg_bank_b;
  assign out_prg_bank_c      = res.prg_bank_c;
  assign out_wram_bank       = res.wram_bank;
  assign out_mirror_vertical = res.mirror_vertical;
  assign out_chr_update      = res.chr_update;
  assign out_chr_slot        = res.chr_slot;
  assign out_chr_bank        = res.chr_bank;

endmodule

>>> rtl/cbim_checker.sv
// ----------------------------------------------------------------------------
// Port checker for the cartridge bank and cycle IRQ mapper
// Watches the top-level ports and flags handshake and result slips.
// ----------------------------------------------------------------------------
`include "cartridge_bank_and_cycle_irq_mapper_top_assert.svh"

module cbim_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_mode,
  input logic [15:0] in_address,
  input logic [7:0]  in_data,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_irq_line,
  input logic [4:0]  out_prg_bank_a,
  input logic [4:0]  out_prg_bank_b,
  input logic [4:0]  out_prg_bank_c,
  input logic [7:0]  out_wram_bank,
  input logic        out_mirror_vertical,
  input logic        out_chr_update,
  input logic [2:0]  out_chr_slot,
  input logic [7:0]  out_chr_bank
);

  logic [36:0] out_bus;
  logic        chr_quiet;

  assign out_bus = {out_irq_line, out_prg_bank_a, out_prg_bank_b, out_prg_bank_c,
                    out_wram_bank, out_mirror_vertical, out_chr_update, out_chr_slot,
                    out_chr_bank};
  assign chr_quiet = (out_chr_slot == 3'd0) && (out_chr_bank == 8'd0);

  `CBIM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_bus), "result moved")

  `CBIM_ASSERT_NOW(a_chr_quiet, out_valid && !out_chr_update, chr_quiet, "chr fields set")

  `CBIM_ASSERT_RST(a_rst_out, !rst_n, !out_valid, "result valid after reset")

  `CBIM_ASSERT_RST(a_rst_in, !rst_n, in_ready, "input not ready after reset")

endmodule

bind cartridge_bank_and_cycle_irq_mapper_top cbim_checker u_cbim_checker (.*);

>>> sim/cartridge_bank_and_cycle_irq_mapper_top_tb.sv
// ----------------------------------------------------------------------------
// Cartridge bank and cycle IRQ mapper testbench
// Drives CPU writes and cycle ticks through the valid/ready input channel,
// predicts the bank and IRQ view after every transaction, and checks each
// result in order. Both sides idle at random, and one long receiver hold-off
// fills the pipeline so that the input stalls.
// ----------------------------------------------------------------------------
module cartridge_bank_and_cycle_irq_mapper_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   RANDOM_ITEMS = 1800;
  localparam int   MAX_GAP      = 11;
  localparam int   HOLD_CYCLES  = 300;
  localparam int   DRAIN_CYCLES = 8;
  localparam int   CYCLE_LIMIT  = 400000;
  localparam logic MODE_WRITE   = 1'b0;
  localparam logic MODE_TICK    = 1'b1;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_mode;
  logic [15:0] in_address;
  logic [7:0]  in_data;
  logic        out_valid;
  logic        out_ready;
  logic        out_irq_line;
  logic [4:0]  out_prg_bank_a;
  logic [4:0]  out_prg_bank_b;
  logic [4:0]  out_prg_bank_c;
  logic [7:0]  out_wram_bank;
  logic        out_mirror_vertical;
  logic        out_chr_update;
  logic [2:0]  out_chr_slot;
  logic [7:0]  out_chr_bank;

  // mapper state as predicted
  logic [15:0] latch_m;
  logic [15:0] count_m;
  logic        irq_en_m;
  logic        irq_pend_m;
  logic [3:0]  sel_m;
  logic [4:0]  prg_m [3];
  logic [7:0]  wram_m;
  logic        mirror_m;
  logic [7:0]  chr_m [cbim_pkg::CHR_SLOTS];

  cbim_pkg::result_t bank_view_q [$];
  cbim_pkg::result_t seen_view;
  cbim_pkg::result_t want_view;
  int      mismatch_count;
  int      items_sent;
  int      cycle_count;
  bit      no_idle;
  bit      hold_req;

  cartridge_bank_and_cycle_irq_mapper_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_address          (in_address),
    .in_data             (in_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_irq_line        (out_irq_line),
    .out_prg_bank_a      (out_prg_bank_a),
    .out_prg_bank_b      (out_prg_bank_b),
    .out_prg_bank_c      (out_prg_bank_c),
    .out_wram_bank       (out_wram_bank),
    .out_mirror_vertical (out_mirror_vertical),
    .out_chr_update      (out_chr_update),
    .out_chr_slot        (out_chr_slot),
    .out_chr_bank        (out_chr_bank)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic cbim_pkg::result_t next_bank_view(input cbim_pkg::item_t it);
    cbim_pkg::result_t r;
    logic [3:0]        nib;
    r   = '0;
    nib = it.data[3:0];
    if (it.mode == MODE_TICK) begin
      if (irq_en_m) begin
        if (count_m == cbim_pkg::CNT_MAX) begin
          count_m    = latch_m;
          irq_pend_m = 1'b1;
        end else begin
          count_m = count_m + 16'd1;
        end
      end
    end else if (it.address[15]) begin
      case (it.address[15:12])
        cbim_pkg::RGN_LATCH0: latch_m[3:0]   = nib;
        cbim_pkg::RGN_LATCH1: latch_m[7:4]   = nib;
        cbim_pkg::RGN_LATCH2: latch_m[11:8]  = nib;
        cbim_pkg::RGN_LATCH3: latch_m[15:12] = nib;
        cbim_pkg::RGN_IRQ_CTRL: begin
          irq_en_m = (nib != 4'h0);
          if (irq_en_m) count_m = latch_m;
          irq_pend_m = 1'b0;
        end
        cbim_pkg::RGN_IRQ_ACK: irq_pend_m = 1'b0;
        cbim_pkg::RGN_BANK_SEL: sel_m = nib;
        cbim_pkg::RGN_BANK_DATA: begin
          case (sel_m)
            cbim_pkg::SEL_PRG_A: prg_m[cbim_pkg::PRG_IDX_A][3:0] = nib;
            cbim_pkg::SEL_PRG_B: prg_m[cbim_pkg::PRG_IDX_B][3:0] = nib;
            cbim_pkg::SEL_PRG_C: prg_m[cbim_pkg::PRG_IDX_C][3:0] = nib;
            cbim_pkg::SEL_WRAM:  wram_m = it.data;
            default: ;
          endcase
          case (it.address[11:10])
            cbim_pkg::SUB_PRG_HI: begin
              case (it.address[1:0]) inside
                cbim_pkg::PRG_IDX_A, cbim_pkg::PRG_IDX_B, cbim_pkg::PRG_IDX_C:
                  prg_m[it.address[1:0]][4] = it.data[4];
                default: ;
              endcase
            end
            cbim_pkg::SUB_MIRROR: mirror_m = it.data[0];
            cbim_pkg::SUB_CHR: begin
              chr_m[it.address[2:0]] = it.data;
              r.chr_update = 1'b1;
              r.chr_slot   = it.address[2:0];
              r.chr_bank   = it.data;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    r.irq_line        = irq_pend_m;
    r.prg_bank_a      = prg_m[cbim_pkg::PRG_IDX_A];
    r.prg_bank_b      = prg_m[cbim_pkg::PRG_IDX_B];
    r.prg_bank_c      = prg_m[cbim_pkg::PRG_IDX_C];
    r.wram_bank       = wram_m;
    r.mirror_vertical = mirror_m;
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic send_item(input logic mode, input logic [15:0] addr, input logic [7:0] data);
    cbim_pkg::item_t it;
    int              gap;
    it.mode    = mode;
    it.address = addr;
    it.data    = data;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    bank_view_q.push_back(next_bank_view(it));
    in_valid   <= 1'b1;
    in_mode    <= it.mode;
    in_address <= it.address;
    in_data    <= it.data;
    items_sent++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_write(input logic [3:0] region, input logic [11:0] low,
                            input logic [7:0] data);
    send_item(MODE_WRITE, {region, low}, data);
  endtask

  task automatic send_tick();
    send_item(MODE_TICK, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
  endtask

  task automatic test_latch_and_irq();
    send_write(cbim_pkg::RGN_LATCH0, 12'h000, 8'hFC);
    send_write(cbim_pkg::RGN_LATCH1, 12'hFFF, 8'h0F);
    send_write(cbim_pkg::RGN_LATCH2, 12'h5A5, 8'hFF);
    send_write(cbim_pkg::RGN_LATCH3, 12'h123, 8'hEF);
    send_write(cbim_pkg::RGN_IRQ_CTRL, 12'h000, 8'h01);
    send_item(MODE_TICK, 16'h0000, 8'h00);
    send_item(MODE_TICK, 16'hFFFF, 8'hFF);
    send_item(MODE_TICK, 16'h7FFF, 8'h80);
    send_item(MODE_TICK, 16'h8000, 8'h7F);
    send_tick();
    send_write(cbim_pkg::RGN_IRQ_ACK, 12'hFFF, 8'hFF);
    send_write(cbim_pkg::RGN_IRQ_CTRL, 12'hABC, 8'hF0);
    send_tick();
  endtask

  task automatic test_bank_writes();
    send_write(cbim_pkg::RGN_BANK_SEL, 12'h000, {4'h0, cbim_pkg::SEL_PRG_A});
    send_write(cbim_pkg::RGN_BANK_DATA, {cbim_pkg::SUB_PRG_HI, 10'h000}, 8'hFF);
    send_write(cbim_pkg::RGN_BANK_SEL, 12'hFFF, {4'hF, cbim_pkg::SEL_PRG_B});
    send_write(cbim_pkg::RGN_BANK_DATA, {cbim_pkg::SUB_PRG_HI, 10'h3FF}, 8'h1F);
    send_write(cbim_pkg::RGN_BANK_SEL, 12'h555, {4'hA, cbim_pkg::SEL_PRG_C});
    send_write(cbim_pkg::RGN_BANK_DATA, {cbim_pkg::SUB_MIRROR, 10'h2AA}, 8'h01);
    send_write(cbim_pkg::RGN_BANK_SEL, 12'h0F0, {4'h5, cbim_pkg::SEL_WRAM});
    send_write(cbim_pkg::RGN_BANK_DATA, {cbim_pkg::SUB_CHR, 10'h3FF}, 8'hFF);
    send_write(cbim_pkg::RGN_BANK_SEL, 12'h00F, 8'h00);
    send_write(cbim_pkg::RGN_BANK_DATA, {cbim_pkg::SUB_NONE, 10'h155}, 8'hAA);
    send_write(cbim_pkg::RGN_BANK_SEL, 12'hF00, 8'hFF);
    send_write(cbim_pkg::RGN_BANK_DATA, {cbim_pkg::SUB_CHR, 10'h000}, 8'h00);
    send_item(MODE_WRITE, 16'h7FFF, 8'hFF);
    send_item(MODE_WRITE, 16'h0000, 8'h00);
  endtask

  task automatic test_backpressure();
    no_idle  = 1'b1;
    hold_req = 1'b1;
    repeat (40) begin
      if ($urandom_range(0, 2) == 0) send_tick();
      else send_item(MODE_WRITE, 16'($urandom_range(16'h8000, 16'hFFFF)),
                     8'($urandom_range(0, 255)));
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic(input int count);
    int         target;
    int         runs;
    logic [3:0] nib;
    logic [3:0] top;
    target = items_sent + count;
    while (items_sent < target) begin
      no_idle = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          top = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'hF;
          send_write(cbim_pkg::RGN_LATCH0, 12'($urandom_range(0, 4095)),
                     {4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))});
          send_write(cbim_pkg::RGN_LATCH1, 12'($urandom_range(0, 4095)),
                     {4'($urandom_range(0, 15)), top});
          send_write(cbim_pkg::RGN_LATCH2, 12'($urandom_range(0, 4095)),
                     {4'($urandom_range(0, 15)), top});
          send_write(cbim_pkg::RGN_LATCH3, 12'($urandom_range(0, 4095)),
                     {4'($urandom_range(0, 15)), top});
          nib = ($urandom_range(0, 7) == 0) ? 4'h0 : 4'($urandom_range(1, 15));
          send_write(cbim_pkg::RGN_IRQ_CTRL, 12'($urandom_range(0, 4095)),
                     {4'($urandom_range(0, 15)), nib});
          runs = $urandom_range(1, 24);
          repeat (runs) send_tick();
          if ($urandom_range(0, 1) == 1)
            send_write(cbim_pkg::RGN_IRQ_ACK, 12'($urandom_range(0, 4095)),
                       8'($urandom_range(0, 255)));
        end
        3, 4, 5: begin
          nib = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(0, 4));
          send_write(cbim_pkg::RGN_BANK_SEL, 12'($urandom_range(0, 4095)),
                     {4'($urandom_range(0, 15)), nib});
          runs = $urandom_range(1, 4);
          repeat (runs)
            send_write(cbim_pkg::RGN_BANK_DATA, 12'($urandom_range(0, 4095)),
                       8'($urandom_range(0, 255)));
        end
        6, 7: begin
          runs = $urandom_range(1, 8);
          repeat (runs) send_tick();
        end
        default: begin
          runs = $urandom_range(1, 4);
          repeat (runs) begin
            if ($urandom_range(0, 15) == 0)
              send_item(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                        8'($urandom_range(0, 255)));
            else
              send_item(1'($urandom_range(0, 1)), 16'($urandom_range(16'h8000, 16'hFFFF)),
                        8'($urandom_range(0, 255)));
          end
        end
      endcase
    end
    no_idle = 1'b0;
  endtask

  initial begin : receiver
    int stall;
    int hold_left;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        hold_left = HOLD_CYCLES;
        while (hold_left > 0) begin
          @(posedge clk);
          hold_left--;
        end
        hold_req = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_view = {out_irq_line, out_prg_bank_a, out_prg_bank_b, out_prg_bank_c,
                   out_wram_bank, out_mirror_vertical, out_chr_update, out_chr_slot,
                   out_chr_bank};
      if (bank_view_q.size() == 0) begin
        flag_mismatch($sformatf("result %0h with none expected", seen_view));
      end else begin
        want_view = bank_view_q.pop_front();
        check_field("irq_line", 8'(seen_view.irq_line), 8'(want_view.irq_line));
        check_field("prg_bank_a", 8'(seen_view.prg_bank_a), 8'(want_view.prg_bank_a));
        check_field("prg_bank_b", 8'(seen_view.prg_bank_b), 8'(want_view.prg_bank_b));
        check_field("prg_bank_c", 8'(seen_view.prg_bank_c), 8'(want_view.prg_bank_c));
        check_field("wram_bank", seen_view.wram_bank, want_view.wram_bank);
        check_field("mirror_vertical", 8'(seen_view.mirror_vertical),
                    8'(want_view.mirror_vertical));
        check_field("chr_update", 8'(seen_view.chr_update), 8'(want_view.chr_update));
        check_field("chr_slot", 8'(seen_view.chr_slot), 8'(want_view.chr_slot));
        check_field("chr_bank", seen_view.chr_bank, want_view.chr_bank);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int idx;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mode        = 1'b0;
    in_address     = '0;
    in_data        = '0;
    no_idle        = 1'b0;
    hold_req       = 1'b0;
    items_sent     = 0;
    mismatch_count = 0;
    latch_m        = '0;
    count_m        = '0;
    irq_en_m       = 1'b0;
    irq_pend_m     = 1'b0;
    sel_m          = '0;
    wram_m         = '0;
    mirror_m       = 1'b0;
    for (idx = 0; idx < 3; idx++) prg_m[idx] = '0;
    for (idx = 0; idx < cbim_pkg::CHR_SLOTS; idx++) chr_m[idx] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_latch_and_irq();
    test_bank_writes();
    test_backpressure();
    test_random_traffic(RANDOM_ITEMS);
    in_valid <= 1'b0;
    while (bank_view_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
